FILE: sv/tql_pkg.sv
`default_nettype none

package tql_pkg;

	// fixed field widths
	localparam int KEY_W   = 64;
	localparam int VALUE_W = 32;
	localparam int FACT_W  = 16;

	// temporal difference needs two extra bits over a value
	localparam int TD_W   = VALUE_W + 2;
	localparam int PROD_W = TD_W + FACT_W + 1;
	localparam int SH_W   = PROD_W - FACT_W;
	localparam int SUM_W  = TD_W + 2;

	localparam logic [FACT_W-1:0] LR_RESET   = 16'd3277;
	localparam logic [FACT_W-1:0] DISC_RESET = 16'd64881;

	localparam logic signed [SUM_W-1:0] SUM_MAX =
		{{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN =
		{{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

	typedef enum logic [0:0] {
		OP_CHOOSE = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_LR   = 1'b0,
		REG_DISC = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_INSERT,
		ST_BEST,
		ST_CUR_RD,
		ST_MUL_DISC,
		ST_TD,
		ST_MUL_RATE,
		ST_WRITE,
		ST_RESP
	} state_t;

	// clamp a widened sum to the signed value range
	function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [SUM_W-1:0] v);
		logic signed [VALUE_W-1:0] r;
		if (v > SUM_MAX) begin
			r = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (v < SUM_MIN) begin
			r = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			r = v[VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/tql_if.sv
`default_nettype none

interface tql_req_if import tql_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [KEY_W-1:0]          state_key;
	logic                      explore;
	logic [1:0]                random_pick;
	logic [1:0]                action;
	logic signed [VALUE_W-1:0] reward;
	logic [KEY_W-1:0]          next_key;

	modport source (
		output valid, op, state_key, explore, random_pick, action, reward, next_key,
		input  ready
	);
	modport sink (
		input  valid, op, state_key, explore, random_pick, action, reward, next_key,
		output ready
	);
endinterface

interface tql_rsp_if import tql_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                chosen_action;
	logic signed [VALUE_W-1:0] new_value;
	logic                      status;

	modport source (
		output valid, chosen_action, new_value, status,
		input  ready
	);
	modport sink (
		input  valid, chosen_action, new_value, status,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/tql_ram.sv
`default_nettype none

module tql_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  wire [WIDTH-1:0]  wdata,
	input  wire [AW-1:0]     raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/tql_mulsh.sv
`default_nettype none

module tql_mulsh import tql_pkg::*; (
	input  wire                     clk,
	input  wire [FACT_W-1:0]        factor,
	input  wire signed [TD_W-1:0]   operand,
	output logic signed [SH_W-1:0]  result
);

	logic signed [FACT_W:0]   factor_s;
	logic signed [PROD_W-1:0] prod;
	logic signed [SH_W-1:0]   result_q;

	// unsigned Q0.16 factor times signed operand, floor of the product over 2^16
	assign factor_s = {1'b0, factor};
	assign prod     = factor_s * operand;

	always_ff @(posedge clk) begin
		result_q <= prod[PROD_W-1:FACT_W];
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: sv/tabular_q_learning_update_core.sv
// Tabular Q-learning value table.
// Input channel req carries one word per operation: op 0 looks up (or inserts)
// state_key and answers an action, greedy or random_pick when explore is set;
// op 1 inserts missing keys and applies the Q update to state_key/action.
// Output channel rsp returns exactly one word per input word: chosen_action,
// new_value and status (1 = table full, nothing changed).
// Keys and values sit in two single-port-read RAMs; one registered multiplier
// is reused for the discount and the learning-rate products.
// The key scan compares each stored key against both keys in the same pass;
// then missing rows are inserted, the row maximum is found and, for an update,
// the Q update arithmetic runs and the new value is written back.
// One operation is in flight at a time; req.ready is high only while idle.
// A finished word waits in the output register; a stalled rsp holds it and the
// next finished word waits in the sequencer until it is taken.
// Reset empties the table (used count zero) and loads the default learning
// rate and discount; no clearing pass is needed. Registers are written over
// the APB port at byte address 0 (learning rate) and 4 (discount).
`default_nettype none

module tabular_q_learning_update_core import tql_pkg::*; #(
	parameter int ENTRIES     = 64,
	parameter int NUM_ACTIONS = 3
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [2:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	tql_req_if.sink    req,
	tql_rsp_if.source  rsp
);

	localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int VD  = ENTRIES * NUM_ACTIONS;
	localparam int VAW = $clog2(VD);
	localparam int VBW = $clog2(VD + 1);
	localparam int AW  = $clog2(NUM_ACTIONS);
	localparam int ACW = $clog2(NUM_ACTIONS + 1);

	// configuration registers
	logic [FACT_W-1:0] lr_q;
	logic [FACT_W-1:0] disc_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	// sequencer
	state_t state_q;
	state_t state_d;

	// captured request
	op_t                       op_q;
	logic [KEY_W-1:0]          skey_q;
	logic [KEY_W-1:0]          nkey_q;
	logic                      explore_q;
	logic [1:0]                pick_q;
	logic [AW-1:0]             act_q;
	logic signed [VALUE_W-1:0] reward_q;
	logic                      key_eq_q;

	// table fill
	logic [CW-1:0]  used_q;
	logic [VBW-1:0] ubase_q;

	// key scan
	logic [CW-1:0]  idx_q;
	logic [VBW-1:0] base_q;
	logic           cmp_vld_s1;
	logic [VAW-1:0] cmp_base_s1;
	logic           s_hit_q;
	logic           n_hit_q;
	logic [VAW-1:0] s_base_q;
	logic [VAW-1:0] n_base_q;

	// row walk and arithmetic
	logic [ACW-1:0]            a_q;
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_act_s1;
	logic [AW-1:0]             best_act_q;
	logic signed [VALUE_W-1:0] best_val_q;
	logic signed [VALUE_W-1:0] cur_q;
	logic [VAW-1:0]            upd_addr_q;
	logic signed [TD_W-1:0]    td_q;
	logic signed [VALUE_W-1:0] nv_q;
	logic                      fail_q;

	// output register
	logic                      rsp_vld_q;
	logic [1:0]                rsp_act_q;
	logic signed [VALUE_W-1:0] rsp_val_q;
	logic                      rsp_st_q;

	// combinational control
	logic             search_issue;
	logic             best_issue;
	logic             s_need;
	logic             n_need;
	logic [1:0]       need;
	logic             table_full;
	logic             ins_n;
	logic             ins_pending;
	logic             ins_last;
	logic [KEY_W-1:0] ins_key;
	logic [VBW-1:0]   ins_sum;
	logic [VBW-1:0]   best_sum;
	logic [VBW-1:0]   upd_sum;
	logic             rsp_free;
	logic [1:0]       pick_mod;
	logic [1:0]       chosen;

	// memory and multiplier ports
	logic                   key_we;
	logic [IW-1:0]          key_waddr;
	logic [IW-1:0]          key_raddr;
	logic [KEY_W-1:0]       key_rdata;
	logic                   val_we;
	logic [VAW-1:0]         val_waddr;
	logic [VALUE_W-1:0]     val_wdata;
	logic [VAW-1:0]         val_raddr;
	logic [VALUE_W-1:0]     val_rdata;
	logic [FACT_W-1:0]      mul_factor;
	logic signed [TD_W-1:0] mul_operand;
	logic signed [SH_W-1:0] mul_result;

	logic signed [SUM_W-1:0] td_sum;
	logic signed [SUM_W-1:0] nv_sum;

	tql_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (ins_key),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	tql_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (VD)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	tql_mulsh u_mulsh (
		.clk     (clk),
		.factor  (mul_factor),
		.operand (mul_operand),
		.result  (mul_result)
	);

	// APB register port, always ready
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= LR_RESET;
			disc_q <= DISC_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_LR:   lr_q   <= pwdata[FACT_W-1:0];
				REG_DISC: disc_q <= pwdata[FACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_LR:   prdata = {{(32-FACT_W){1'b0}}, lr_q};
			REG_DISC: prdata = {{(32-FACT_W){1'b0}}, disc_q};
			default:  prdata = '0;
		endcase
	end

	// decisions shared by next state and datapath
	assign search_issue = idx_q < used_q;
	assign best_issue   = a_q < ACW'(NUM_ACTIONS);
	assign s_need       = !s_hit_q;
	assign n_need       = (op_q == OP_UPDATE) && !n_hit_q && !(!s_hit_q && key_eq_q);
	assign need         = {1'b0, s_need} + {1'b0, n_need};
	assign table_full   = (32'(used_q) + 32'(need)) > 32'(ENTRIES);
	assign ins_n        = (op_q == OP_UPDATE) && !n_hit_q;
	assign ins_pending  = ins_n || !s_hit_q;
	assign ins_last     = a_q == ACW'(NUM_ACTIONS - 1);
	assign ins_key      = ins_n ? nkey_q : skey_q;
	assign ins_sum      = ubase_q + VBW'(a_q);
	assign best_sum     = VBW'((op_q == OP_UPDATE) ? n_base_q : s_base_q) + VBW'(a_q);
	assign upd_sum      = VBW'(s_base_q) + VBW'(act_q);
	assign rsp_free     = !rsp_vld_q || rsp.ready;
	assign pick_mod     = (32'(pick_q) >= 32'(NUM_ACTIONS)) ?
		2'(32'(pick_q) - 32'(NUM_ACTIONS)) : pick_q;
	assign chosen       = explore_q ? pick_mod : 2'(best_act_q);

	assign td_sum = SUM_W'(reward_q) + SUM_W'(mul_result) - SUM_W'(cur_q);
	assign nv_sum = SUM_W'(cur_q) + SUM_W'(mul_result);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (!search_issue && !cmp_vld_s1) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (table_full) begin
					state_d = ST_RESP;
				end else if (ins_pending) begin
					state_d = ST_INSERT;
				end else begin
					state_d = ST_BEST;
				end
			end
			ST_INSERT: begin
				if (ins_last) state_d = ST_DECIDE;
			end
			ST_BEST: begin
				if (!best_issue && !rd_vld_s1) begin
					state_d = (op_q == OP_UPDATE) ? ST_CUR_RD : ST_RESP;
				end
			end
			ST_CUR_RD:   state_d = ST_MUL_DISC;
			ST_MUL_DISC: state_d = ST_TD;
			ST_TD:       state_d = ST_MUL_RATE;
			ST_MUL_RATE: state_d = ST_WRITE;
			ST_WRITE:    state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory, multiplier and handshake controls
	always_comb begin
		req.ready   = 1'b0;
		key_we      = 1'b0;
		key_waddr   = used_q[IW-1:0];
		key_raddr   = idx_q[IW-1:0];
		val_we      = 1'b0;
		val_waddr   = ins_sum[VAW-1:0];
		val_wdata   = '0;
		val_raddr   = best_sum[VAW-1:0];
		mul_factor  = disc_q;
		mul_operand = TD_W'(best_val_q);
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_INSERT: begin
				key_we = a_q == '0;
				val_we = 1'b1;
			end
			ST_CUR_RD: val_raddr = upd_sum[VAW-1:0];
			ST_MUL_RATE: begin
				mul_factor  = lr_q;
				mul_operand = td_q;
			end
			ST_WRITE: begin
				val_we    = 1'b1;
				val_waddr = upd_addr_q;
				val_wdata = sat_value(nv_sum);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			ubase_q    <= '0;
			idx_q      <= '0;
			base_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			rd_vld_s1  <= 1'b0;
			s_hit_q    <= 1'b0;
			n_hit_q    <= 1'b0;
			a_q        <= '0;
			fail_q     <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SEARCH) && search_issue;
			rd_vld_s1  <= (state_q == ST_BEST) && best_issue;

			// compare the key read last cycle against both keys
			if (cmp_vld_s1) begin
				if (key_rdata == skey_q) s_hit_q <= 1'b1;
				if (key_rdata == nkey_q) n_hit_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						idx_q   <= '0;
						base_q  <= '0;
						s_hit_q <= 1'b0;
						n_hit_q <= 1'b0;
						fail_q  <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (search_issue) begin
						idx_q  <= idx_q + CW'(1);
						base_q <= base_q + VBW'(NUM_ACTIONS);
					end
				end
				ST_DECIDE: begin
					a_q <= '0;
					if (table_full) fail_q <= 1'b1;
				end
				ST_INSERT: begin
					if (ins_last) begin
						a_q     <= '0;
						used_q  <= used_q + CW'(1);
						ubase_q <= ubase_q + VBW'(NUM_ACTIONS);
						if (ins_n) begin
							n_hit_q <= 1'b1;
							if (key_eq_q) s_hit_q <= 1'b1;
						end else begin
							s_hit_q <= 1'b1;
						end
					end else begin
						a_q <= a_q + ACW'(1);
					end
				end
				ST_BEST: begin
					if (best_issue) a_q <= a_q + ACW'(1);
				end
				default: ;
			endcase

			// hold a finished word until the receiver takes it
			if (state_q == ST_RESP && rsp_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (key_rdata == skey_q) s_base_q <= cmp_base_s1;
			if (key_rdata == nkey_q) n_base_q <= cmp_base_s1;
		end
		cmp_base_s1 <= base_q[VAW-1:0];
		rd_act_s1   <= a_q[AW-1:0];

		// keep the first maximum of the row
		if (rd_vld_s1 && (rd_act_s1 == '0 || $signed(val_rdata) > best_val_q)) begin
			best_val_q <= val_rdata;
			best_act_q <= rd_act_s1;
		end

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_q      <= op_t'(req.op);
					skey_q    <= req.state_key;
					nkey_q    <= req.next_key;
					explore_q <= req.explore;
					pick_q    <= req.random_pick;
					act_q     <= (32'(req.action) >= 32'(NUM_ACTIONS)) ?
						AW'(NUM_ACTIONS - 1) : AW'(req.action);
					reward_q  <= req.reward;
					key_eq_q  <= req.state_key == req.next_key;
				end
			end
			ST_INSERT: begin
				if (ins_last) begin
					if (ins_n) begin
						n_base_q <= ubase_q[VAW-1:0];
						if (key_eq_q) s_base_q <= ubase_q[VAW-1:0];
					end else begin
						s_base_q <= ubase_q[VAW-1:0];
					end
				end
			end
			ST_CUR_RD:   upd_addr_q <= upd_sum[VAW-1:0];
			ST_MUL_DISC: cur_q <= val_rdata;
			ST_TD:       td_q <= td_sum[TD_W-1:0];
			ST_WRITE:    nv_q <= sat_value(nv_sum);
			ST_RESP: begin
				if (rsp_free) begin
					rsp_st_q  <= fail_q;
					rsp_act_q <= (fail_q || op_q == OP_UPDATE) ? 2'b00 : chosen;
					rsp_val_q <= (fail_q || op_q == OP_CHOOSE) ? '0 : nv_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.chosen_action = rsp_act_q;
	assign rsp.new_value     = rsp_val_q;
	assign rsp.status        = rsp_st_q;

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
	import tql_pkg::*;

	localparam int ENTRIES = 64;
	localparam int NUM_ACT = 3;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;
	localparam longint VMAX = longint'(32'h7FFF_FFFF);
	localparam longint VMIN = -VMAX - 1;

	typedef struct {
		op_t                       op;
		logic [KEY_W-1:0]          state_key;
		logic                      explore;
		logic [1:0]                random_pick;
		logic [1:0]                action;
		logic signed [VALUE_W-1:0] reward;
		logic [KEY_W-1:0]          next_key;
	} q_req_t;

	typedef struct {
		logic [1:0]                chosen_action;
		logic signed [VALUE_W-1:0] new_value;
		logic                      status;
	} q_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tql_req_if req ();
	tql_rsp_if rsp ();

	tabular_q_learning_update_core #(
		.ENTRIES    (ENTRIES),
		.NUM_ACTIONS(NUM_ACT)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req),
		.rsp    (rsp)
	);

	// Q table mirror
	logic [KEY_W-1:0] key_tab [ENTRIES];
	longint           val_tab [ENTRIES][NUM_ACT];
	int               rows_used;
	longint           lr_q;
	longint           disc_q;

	q_req_t           pending_words[$];
	q_rsp_t           expected_words[$];
	logic [KEY_W-1:0] key_pool[$];
	int               errors;
	int               quiet_cycles;
	int               req_gap;
	int               rsp_stall;
	bit               req_taken;
	bit               idle_on;

	always #5 clk = ~clk;

	function automatic int row_of(input logic [KEY_W-1:0] k);
		for (int i = 0; i < rows_used; i++) begin
			if (key_tab[i] == k) return i;
		end
		return -1;
	endfunction

	function automatic int add_row(input logic [KEY_W-1:0] k);
		if (rows_used >= ENTRIES) return -1;
		key_tab[rows_used] = k;
		for (int a = 0; a < NUM_ACT; a++) val_tab[rows_used][a] = 0;
		rows_used++;
		return rows_used - 1;
	endfunction

	// lowest index wins a tie
	function automatic int best_of(input int row);
		int b;
		b = 0;
		for (int a = 1; a < NUM_ACT; a++) begin
			if (val_tab[row][a] > val_tab[row][b]) b = a;
		end
		return b;
	endfunction

	function automatic q_rsp_t q_table_step(input q_req_t r);
		q_rsp_t o;
		int     s, n, need, a;
		longint cur, maxn, td, nv;
		o.chosen_action = '0;
		o.new_value = '0;
		o.status = 1'b0;
		if (r.op == OP_CHOOSE) begin
			s = row_of(r.state_key);
			if (s < 0) s = add_row(r.state_key);
			if (s < 0) o.status = 1'b1;
			else if (r.explore) o.chosen_action = 2'(r.random_pick % NUM_ACT);
			else o.chosen_action = 2'(best_of(s));
			return o;
		end
		s = row_of(r.state_key);
		n = row_of(r.next_key);
		need = 0;
		if (s < 0) need++;
		if (n < 0 && !(s < 0 && r.next_key == r.state_key)) need++;
		// table full: leave everything untouched
		if (rows_used + need > ENTRIES) begin
			o.status = 1'b1;
			return o;
		end
		if (n < 0) n = add_row(r.next_key);
		if (s < 0) s = (r.next_key == r.state_key) ? n : add_row(r.state_key);
		a = (r.action >= NUM_ACT) ? NUM_ACT - 1 : int'(r.action);
		cur = val_tab[s][a];
		maxn = val_tab[n][best_of(n)];
		td = longint'(r.reward) + ((disc_q * maxn) >>> 16) - cur;
		nv = cur + ((lr_q * td) >>> 16);
		if (nv > VMAX) nv = VMAX;
		else if (nv < VMIN) nv = VMIN;
		val_tab[s][a] = nv;
		o.new_value = nv[VALUE_W-1:0];
		return o;
	endfunction

	function automatic q_req_t mk(input op_t op, input logic [KEY_W-1:0] sk, input logic e,
			input logic [1:0] p, input logic [1:0] a, input logic [31:0] rw,
			input logic [KEY_W-1:0] nk);
		q_req_t r;
		r.op = op;
		r.state_key = sk;
		r.explore = e;
		r.random_pick = p;
		r.action = a;
		r.reward = rw;
		r.next_key = nk;
		return r;
	endfunction

	// mostly revisit known keys, now and then bring in a fresh one
	function automatic logic [KEY_W-1:0] any_key();
		logic [KEY_W-1:0] k;
		if (key_pool.size() == 0 || $urandom_range(0, 99) < 14) begin
			k = {$urandom, $urandom};
			key_pool.push_back(k);
		end else begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		end
		return k;
	endfunction

	function automatic q_req_t rand_word();
		q_req_t r;
		r.op = op_t'($urandom_range(0, 1));
		r.state_key = any_key();
		r.explore = ($urandom_range(0, 3) == 0);
		r.random_pick = 2'($urandom_range(0, 3));
		r.action = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: r.reward = 32'sh7FFF_FFFF;
			1: r.reward = 32'sh8000_0000;
			2, 3: r.reward = $urandom;
			default: r.reward = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
		if (r.op == OP_UPDATE)
			r.next_key = ($urandom_range(0, 6) == 0) ? r.state_key : any_key();
		else
			r.next_key = {$urandom, $urandom};
		return r;
	endfunction

	task automatic apb_check(input reg_idx_t idx, input logic [15:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {16'h0, want}) begin
			$error("prdata expected %h got %h", {16'h0, want}, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// write, then read back
	task automatic apb_write(input reg_idx_t idx, input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_LR) lr_q = longint'(v);
		else disc_q = longint'(v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apb_check(idx, v);
	endtask

	// hold the sender until every word has come back
	task automatic drain();
		while (pending_words.size() != 0 || req.valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count, input bit idling);
		idle_on = idling;
		repeat (count) pending_words.push_back(rand_word());
		drain();
	endtask

	// request driver
	always @(negedge clk) begin
		if (req_taken || !req.valid) begin
			req_taken = 1'b0;
			if (req_gap > 0) begin
				req_gap--;
				req.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin : launch
				q_req_t w;
				w = pending_words.pop_front();
				req.valid <= 1'b1;
				req.op <= w.op;
				req.state_key <= w.state_key;
				req.explore <= w.explore;
				req.random_pick <= w.random_pick;
				req.action <= w.action;
				req.reward <= w.reward;
				req.next_key <= w.next_key;
				if (idle_on && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 4);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		if (rsp_stall > 0) begin
			rsp_stall--;
			rsp.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall = $urandom_range(0, 3);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// check results, predict on accepted requests, watch for a hang
	always @(posedge clk) begin : monitor
		q_req_t seen;
		q_rsp_t got, want;
		bit     moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rsp.valid && rsp.ready) begin
				moved = 1'b1;
				got.chosen_action = rsp.chosen_action;
				got.new_value = rsp.new_value;
				got.status = rsp.status;
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: action %0d value %0d status %0d",
						got.chosen_action, got.new_value, got.status);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.chosen_action !== want.chosen_action) begin
						$error("chosen_action expected %0d got %0d",
							want.chosen_action, got.chosen_action);
						errors++;
					end
					if (got.new_value !== want.new_value) begin
						$error("new_value expected %0d got %0d", want.new_value, got.new_value);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				moved = 1'b1;
				req_taken = 1'b1;
				seen.op = op_t'(req.op);
				seen.state_key = req.state_key;
				seen.explore = req.explore;
				seen.random_pick = req.random_pick;
				seen.action = req.action;
				seen.reward = req.reward;
				seen.next_key = req.next_key;
				expected_words.push_back(q_table_step(seen));
			end
			if (psel && penable && pready) moved = 1'b1;
			if (moved) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tabular_q_learning_update_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] k0, kf, ka, kb, kc, kd, ke;
		k0 = '0;
		kf = '1;
		ka = 64'h0123_4567_89AB_CDEF;
		kb = 64'hFEDC_BA98_7654_3210;
		kc = 64'h8000_0000_0000_0001;
		kd = 64'h5555_AAAA_5555_AAAA;
		ke = 64'hAAAA_5555_AAAA_5555;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.op = 1'b0;
		req.state_key = '0;
		req.explore = 1'b0;
		req.random_pick = '0;
		req.action = '0;
		req.reward = '0;
		req.next_key = '0;
		rsp.ready = 1'b0;
		rows_used = 0;
		lr_q = longint'(LR_RESET);
		disc_q = longint'(DISC_RESET);
		errors = 0;
		quiet_cycles = 0;
		req_gap = 0;
		rsp_stall = 0;
		req_taken = 1'b0;
		idle_on = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default register values
		apb_check(REG_LR, LR_RESET);
		apb_check(REG_DISC, DISC_RESET);

		// directed words at the default rate and discount
		idle_on = 1'b1;
		key_pool = '{k0, kf, ka, kb, kc, kd, ke};
		pending_words.push_back(mk(OP_CHOOSE, k0, 1'b0, 2'd0, 2'd0, 32'h0, kf));
		pending_words.push_back(mk(OP_CHOOSE, kf, 1'b1, 2'd3, 2'd0, 32'h0, k0));
		pending_words.push_back(mk(OP_CHOOSE, kf, 1'b1, 2'd2, 2'd0, 32'h0, k0));
		pending_words.push_back(mk(OP_CHOOSE, k0, 1'b1, 2'd1, 2'd0, 32'h0, k0));
		pending_words.push_back(mk(OP_UPDATE, k0, 1'b0, 2'd0, 2'd3, 32'h7FFF_FFFF, k0));
		pending_words.push_back(mk(OP_UPDATE, ka, 1'b0, 2'd0, 2'd0, 32'h8000_0000, ka));
		pending_words.push_back(mk(OP_UPDATE, kb, 1'b0, 2'd0, 2'd1, 32'h0001_0000, kc));
		pending_words.push_back(mk(OP_UPDATE, kf, 1'b0, 2'd0, 2'd2, 32'h7FFF_FFFF, k0));
		pending_words.push_back(mk(OP_UPDATE, kf, 1'b0, 2'd0, 2'd0, 32'h8000_0000, kf));
		pending_words.push_back(mk(OP_CHOOSE, kf, 1'b0, 2'd3, 2'd3, 32'h0, kf));
		// equal values in actions 1 and 2 of kd: the tie goes to 1
		pending_words.push_back(mk(OP_UPDATE, kd, 1'b0, 2'd0, 2'd1, 32'h0002_0000, ke));
		pending_words.push_back(mk(OP_UPDATE, kd, 1'b0, 2'd0, 2'd2, 32'h0002_0000, ka));
		pending_words.push_back(mk(OP_CHOOSE, kd, 1'b0, 2'd0, 2'd0, 32'h0, kd));
		pending_words.push_back(mk(OP_CHOOSE, ka, 1'b0, 2'd0, 2'd0, 32'h0, ka));
		pending_words.push_back(mk(OP_CHOOSE, kb, 1'b1, 2'd0, 2'd0, 32'h0, kb));
		pending_words.push_back(mk(OP_UPDATE, k0, 1'b0, 2'd0, 2'd2, 32'hFFFF_FFFF, kf));
		pending_words.push_back(mk(OP_UPDATE, kc, 1'b0, 2'd0, 2'd3, 32'h0, kb));
		pending_words.push_back(mk(OP_UPDATE, ke, 1'b1, 2'd3, 2'd1, 32'h8000_0000, kd));
		drain();

		// full rate and discount push values into saturation
		apb_write(REG_LR, 16'hFFFF);
		apb_write(REG_DISC, 16'hFFFF);
		random_phase(80, 1'b1);

		// zero rate: values freeze
		apb_write(REG_LR, 16'h0000);
		apb_write(REG_DISC, 16'h0000);
		random_phase(60, 1'b0);

		apb_write(REG_LR, 16'h8000);
		apb_write(REG_DISC, 16'($urandom));
		random_phase(100, 1'b1);

		apb_write(REG_LR, 16'($urandom));
		apb_write(REG_DISC, 16'($urandom));
		random_phase(100, 1'b1);

		// last stretch without idling
		apb_write(REG_LR, 16'hFFFF);
		apb_write(REG_DISC, 16'h0000);
		random_phase(90, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tabular_q_learning_update_core verification clean");
		end else begin
			$display("tabular_q_learning_update_core verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
sv/tql_pkg.sv
sv/tql_if.sv
sv/tql_ram.sv
sv/tql_mulsh.sv
sv/tabular_q_learning_update_core.sv
bench/tb.sv
